[rtl/fpvm_pkg.sv]
// Shared types, constants and helper functions of the voice mixer.
package fpvm_pkg;

  localparam int unsigned SineDepth = 256;
  localparam int unsigned RateW     = 18;
  localparam int unsigned LenW      = 20;
  localparam int unsigned IncNumW   = 48;
  localparam int unsigned EnvNumW   = 35;
  localparam int unsigned StepsW    = LenW + 1;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;
  localparam logic [RateW-1:0] RateReset = 18'd48000;
  localparam logic [14:0] Q15Max = 15'h7fff;

  localparam logic [15:0] SineQuarter [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
    16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
    16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
    16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
    16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
    16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
    16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
    16'd32767
  };

  typedef enum logic [1:0] {
    WaveSine   = 2'd0,
    WaveSquare = 2'd1,
    WaveNoise  = 2'd2
  } wave_e;

  typedef enum logic [1:0] {
    EnvRel = 2'd0,
    EnvAtt = 2'd1,
    EnvDec = 2'd2,
    EnvSus = 2'd3
  } env_mode_e;

  typedef struct packed {
    logic [1:0]        wave_kind;
    logic [15:0]       freq_hz;
    logic signed [15:0] pan_position;
    logic signed [15:0] voice_gain;
    logic [LenW-1:0]   attack_len;
    logic [LenW-1:0]   decay_len;
    logic [14:0]       sustain_level;
    logic [LenW-1:0]   release_len;
    logic [LenW-1:0]   voice_length;
    logic [LenW-1:0]   sample_offset;
    logic [31:0]       noise_seed;
    logic              last_of_frame;
  } voice_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic start;
    logic phase;
    logic osc;
    logic mul1;
    logic mul2;
    logic mull;
    logic mulr;
    logic emit;
  } fpvm_cmd_t;

  typedef struct packed {
    logic active;
    logic last;
    logic units_done;
    logic out_free;
  } fpvm_sts_t;

  // Full-wave sine from the mirrored quarter table.
  function automatic logic signed [16:0] sine_lookup(input logic [7:0] idx);
    logic [6:0]  h;
    logic [6:0]  k;
    logic [16:0] v;
    h = idx[6:0];
    k = (h <= 7'd64) ? h : 7'(8'd128 - {1'b0, h});
    v = {1'b0, SineQuarter[k]};
    return idx[7] ? -$signed(v) : $signed(v);
  endfunction

  // Q15 product, rounded toward minus infinity (arithmetic shift).
  function automatic logic signed [16:0] q15_trunc(input logic signed [33:0] p);
    return p[31:15];
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [31:0] acc);
    if (acc > 32'sd32767) return 16'sd32767;
    if (acc < -32'sd32768) return -16'sd32768;
    return acc[15:0];
  endfunction

endpackage

[rtl/fpvm_if.sv]
// Channel interfaces: voice items in, frame samples out, rate register writes.
interface fpvm_voice_if;
  logic               valid;
  logic               ready;
  logic [1:0]         wave_kind;
  logic [15:0]        freq_hz;
  logic signed [15:0] pan_position;
  logic signed [15:0] voice_gain;
  logic [19:0]        attack_len;
  logic [19:0]        decay_len;
  logic [14:0]        sustain_level;
  logic [19:0]        release_len;
  logic [19:0]        voice_length;
  logic [19:0]        sample_offset;
  logic [31:0]        noise_seed;
  logic               last_of_frame;

  modport source (output valid, wave_kind, freq_hz, pan_position, voice_gain, attack_len,
                  decay_len, sustain_level, release_len, voice_length, sample_offset,
                  noise_seed, last_of_frame, input ready);
  modport sink (input valid, wave_kind, freq_hz, pan_position, voice_gain, attack_len,
                decay_len, sustain_level, release_len, voice_length, sample_offset,
                noise_seed, last_of_frame, output ready);
endinterface

interface fpvm_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface fpvm_cfg_if;
  logic        valid;
  logic        ready;
  logic [17:0] sample_rate;

  modport source (output valid, sample_rate, input ready);
  modport sink (input valid, sample_rate, output ready);
endinterface

[rtl/fixed_point_voice_mixer_core.sv]
// Top level of the stereo voice mixer.
// Usage: each voice transaction on in_i adds one voice's contribution to
// the current stereo frame. A transaction with last_of_frame set emits the
// clamped left/right sums on out_o and clears both accumulators.
// cfg_i writes the sample rate register; write it only while idle.
// Throughput: one item at a time. An item whose offset is not
// below its length (or with a zero rate) skips the arithmetic units. A
// sounding item runs through the sequencing states and waits on the
// arithmetic units, that is on the longer of the increment divider and
// the LCG jump-ahead (square-and-multiply over each bit of offset+1, up
// to 21 bits); the envelope divider runs alongside.
// The result sits in an output register, so the next item is accepted
// while a frame waits; if the receiver stalls and another frame end
// arrives, the block holds that item until the register frees.
// Reset clears the accumulators, the output valid and the controller and
// loads a sample rate of 48000.
module fixed_point_voice_mixer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpvm_voice_if.sink    in_i,
  fpvm_frame_if.source  out_o,
  fpvm_cfg_if.sink      cfg_i
);

  fpvm_pkg::fpvm_cmd_t cmd;
  fpvm_pkg::fpvm_sts_t sts;
  fpvm_pkg::voice_t    voice;

  assign voice.wave_kind     = in_i.wave_kind;
  assign voice.freq_hz       = in_i.freq_hz;
  assign voice.pan_position  = in_i.pan_position;
  assign voice.voice_gain    = in_i.voice_gain;
  assign voice.attack_len    = in_i.attack_len;
  assign voice.decay_len     = in_i.decay_len;
  assign voice.sustain_level = in_i.sustain_level;
  assign voice.release_len   = in_i.release_len;
  assign voice.voice_length  = in_i.voice_length;
  assign voice.sample_offset = in_i.sample_offset;
  assign voice.noise_seed    = in_i.noise_seed;
  assign voice.last_of_frame = in_i.last_of_frame;

  assign cfg_i.ready = 1'b1;

  fpvm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fpvm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .voice_i    (voice),
    .cfg_we_i   (cfg_i.valid),
    .cfg_rate_i (cfg_i.sample_rate),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .left_o     (out_o.left_sample),
    .right_o    (out_o.right_sample)
  );

endmodule

[rtl/fpvm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module fpvm_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;
  logic            ge;

  assign shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : shifted;
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[rtl/fpvm_lcg.sv]
// LCG jump-ahead by square-and-multiply over a shared 32-bit multiplier.
module fpvm_lcg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  seed_i,
  input  logic [fpvm_pkg::StepsW-1:0]  steps_i,
  output logic                         busy_o,
  output logic [31:0]                  state_o
);

  logic                        busy_q;
  logic                        fin_q;
  logic [1:0]                  sub_q;
  logic [fpvm_pkg::StepsW-1:0] steps_q;
  logic [31:0] cm_q, cp_q, am_q, ap_q, seed_q, res_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_full;
  logic [31:0] prod;

  always_comb begin
    mul_a = am_q;
    mul_b = cm_q;
    if (fin_q) begin
      mul_a = am_q;
      mul_b = seed_q;
    end else begin
      case (sub_q)
        2'd0: begin mul_a = am_q;          mul_b = cm_q; end
        2'd1: begin mul_a = ap_q;          mul_b = cm_q; end
        2'd2: begin mul_a = cm_q + 32'd1;  mul_b = cp_q; end
        default: begin mul_a = cm_q;       mul_b = cm_q; end
      endcase
    end
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      sub_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      sub_q  <= '0;
    end else if (busy_q) begin
      if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else begin
        sub_q <= sub_q + 2'd1;
        if (sub_q == 2'd3 && steps_q[fpvm_pkg::StepsW-1:1] == '0) fin_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cm_q    <= fpvm_pkg::LcgMul;
      cp_q    <= fpvm_pkg::LcgAdd;
      am_q    <= 32'd1;
      ap_q    <= 32'd0;
      seed_q  <= seed_i;
      steps_q <= steps_i;
    end else if (busy_q) begin
      if (fin_q) begin
        res_q <= prod + ap_q;
      end else begin
        case (sub_q)
          2'd0: if (steps_q[0]) am_q <= prod;
          2'd1: if (steps_q[0]) ap_q <= prod + cp_q;
          2'd2: cp_q <= prod;
          default: begin
            cm_q    <= prod;
            steps_q <= steps_q >> 1;
          end
        endcase
      end
    end
  end

  assign busy_o  = busy_q;
  assign state_o = res_q;

endmodule

[rtl/fpvm_datapath.sv]
// Mixer datapath: item registers, envelope, oscillator, Q15 products, accumulators.
module fpvm_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fpvm_pkg::fpvm_cmd_t                cmd_i,
  output fpvm_pkg::fpvm_sts_t                sts_o,
  input  fpvm_pkg::voice_t                   voice_i,
  input  logic                               cfg_we_i,
  input  logic [fpvm_pkg::RateW-1:0]         cfg_rate_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [15:0]                 left_o,
  output logic signed [15:0]                 right_o
);

  fpvm_pkg::voice_t             item_q;
  logic [fpvm_pkg::RateW-1:0]   rate_q;
  fpvm_pkg::env_mode_e          mode_q, mode_d;
  logic [fpvm_pkg::EnvNumW-1:0] num_q;
  logic [fpvm_pkg::LenW-1:0]    den_q, den_d;
  logic [31:0]                  phase_q;
  logic [15:0]                  env_q;
  logic signed [16:0]           osc_q;
  logic signed [16:0]           smp_q;
  logic [31:0]                  acc_l_q, acc_r_q;
  logic                         out_valid_q;
  logic signed [15:0]           left_q, right_q;

  logic [fpvm_pkg::LenW-1:0] t, dur, a_len, d_len, r_len;
  logic [14:0]               f15;
  logic [fpvm_pkg::LenW-1:0] f20;
  logic rel_hit, att_hit, dec_hit;
  logic inc_busy, env_busy, lcg_busy;
  logic [fpvm_pkg::IncNumW-1:0] inc_quo;
  logic [fpvm_pkg::EnvNumW-1:0] env_quo;
  logic [31:0]                  lcg_state;
  logic [51:0]                  phase_full;
  logic [15:0]                  env_d;
  logic signed [16:0]           osc_d;
  logic signed [17:0]           pan_l_raw, pan_r_raw;
  logic [15:0]                  pan_l, pan_r;
  logic signed [16:0]           mul_a, mul_b;
  logic signed [33:0]           prod;
  logic signed [16:0]           prod_q15;

  assign t     = item_q.sample_offset;
  assign dur   = item_q.voice_length;
  assign a_len = item_q.attack_len;
  assign d_len = item_q.decay_len;
  assign r_len = item_q.release_len;

  // Pick the envelope segment and form its dividend and divisor.
  always_comb begin
    rel_hit = (r_len != '0) && (({1'b0, t} + {1'b0, r_len}) >= {1'b0, dur});
    att_hit = (a_len != '0) && (t < a_len);
    dec_hit = (d_len != '0) && ({1'b0, t} < ({1'b0, a_len} + {1'b0, d_len}));
    if (rel_hit) begin
      mode_d = fpvm_pkg::EnvRel;
      f15    = item_q.sustain_level;
      f20    = dur - t;
      den_d  = r_len;
    end else if (att_hit) begin
      mode_d = fpvm_pkg::EnvAtt;
      f15    = fpvm_pkg::Q15Max;
      f20    = t;
      den_d  = a_len;
    end else if (dec_hit) begin
      mode_d = fpvm_pkg::EnvDec;
      f15    = fpvm_pkg::Q15Max - item_q.sustain_level;
      f20    = t - a_len;
      den_d  = d_len;
    end else begin
      mode_d = fpvm_pkg::EnvSus;
      f15    = '0;
      f20    = '0;
      den_d  = fpvm_pkg::LenW'(1);
    end
  end

  fpvm_div #(.NumW(fpvm_pkg::IncNumW), .DenW(fpvm_pkg::RateW)) u_inc_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  ({item_q.freq_hz, 32'd0}),
    .den_i  (rate_q),
    .busy_o (inc_busy),
    .quo_o  (inc_quo)
  );

  fpvm_div #(.NumW(fpvm_pkg::EnvNumW), .DenW(fpvm_pkg::LenW)) u_env_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  (num_q),
    .den_i  (den_q),
    .busy_o (env_busy),
    .quo_o  (env_quo)
  );

  fpvm_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .seed_i (item_q.noise_seed),
    .steps_i({1'b0, t} + fpvm_pkg::StepsW'(1)),
    .busy_o (lcg_busy),
    .state_o(lcg_state)
  );

  assign phase_full = t * inc_quo[31:0];

  always_comb begin
    case (mode_q)
      fpvm_pkg::EnvRel,
      fpvm_pkg::EnvAtt: env_d = env_quo[15:0];
      fpvm_pkg::EnvDec: env_d = 16'd32767 - env_quo[15:0];
      default:          env_d = {1'b0, item_q.sustain_level};
    endcase
  end

  always_comb begin
    case (item_q.wave_kind)
      fpvm_pkg::WaveSine:   osc_d = fpvm_pkg::sine_lookup(phase_q[31:24]);
      fpvm_pkg::WaveSquare: osc_d = phase_q[31] ? -17'sd32767 : 17'sd32767;
      fpvm_pkg::WaveNoise:  osc_d = {lcg_state[31], lcg_state[31:16]};
      default:              osc_d = '0;
    endcase
  end

  // Linear pan weights, saturated to Q15 one.
  always_comb begin
    pan_l_raw = (18'sd32768 - 18'(item_q.pan_position)) >>> 1;
    pan_r_raw = (18'sd32768 + 18'(item_q.pan_position)) >>> 1;
    pan_l = (pan_l_raw > 18'sd32767) ? 16'd32767 : pan_l_raw[15:0];
    pan_r = pan_r_raw[15:0];
  end

  // One shared Q15 multiplier for every scaling step.
  always_comb begin
    mul_a = smp_q;
    mul_b = {1'b0, pan_r};
    if (cmd_i.mul1) begin
      mul_a = osc_q;
      mul_b = {1'b0, env_q};
    end else if (cmd_i.mul2) begin
      mul_b = {item_q.voice_gain[15], item_q.voice_gain};
    end else if (cmd_i.mull) begin
      mul_b = {1'b0, pan_l};
    end
  end

  assign prod     = mul_a * mul_b;
  assign prod_q15 = fpvm_pkg::q15_trunc(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= fpvm_pkg::RateReset;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rate_q <= cfg_rate_i;
      if (cmd_i.mull) acc_l_q <= acc_l_q + {{15{prod_q15[16]}}, prod_q15};
      if (cmd_i.mulr) acc_r_q <= acc_r_q + {{15{prod_q15[16]}}, prod_q15};
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        acc_l_q     <= '0;
        acc_r_q     <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= voice_i;
    if (cmd_i.prep) begin
      mode_q <= mode_d;
      num_q  <= f15 * f20;
      den_q  <= den_d;
    end
    if (cmd_i.phase) begin
      phase_q <= phase_full[31:0];
      env_q   <= env_d;
    end
    if (cmd_i.osc) osc_q <= osc_d;
    if (cmd_i.mul1 || cmd_i.mul2) smp_q <= prod_q15;
    if (cmd_i.emit) begin
      left_q  <= fpvm_pkg::clamp16(acc_l_q);
      right_q <= fpvm_pkg::clamp16(acc_r_q);
    end
  end

  assign sts_o.active     = (t < dur) && (rate_q != '0);
  assign sts_o.last       = item_q.last_of_frame;
  assign sts_o.units_done = !inc_busy && !env_busy && !lcg_busy;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign left_o      = left_q;
  assign right_o     = right_q;

endmodule

[rtl/fpvm_ctrl.sv]
// Controller that sequences one voice item through the datapath.
module fpvm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpvm_pkg::fpvm_sts_t sts_i,
  output fpvm_pkg::fpvm_cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StStart = 4'd2;
  localparam logic [3:0] StWait  = 4'd3;
  localparam logic [3:0] StPhase = 4'd4;
  localparam logic [3:0] StOsc   = 4'd5;
  localparam logic [3:0] StMul1  = 4'd6;
  localparam logic [3:0] StMul2  = 4'd7;
  localparam logic [3:0] StMulL  = 4'd8;
  localparam logic [3:0] StMulR  = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = StPrep;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.active ? StStart : StFin;
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d     = StWait;
      end
      StWait:  if (sts_i.units_done) state_d = StPhase;
      StPhase: begin cmd_o.phase = 1'b1; state_d = StOsc;  end
      StOsc:   begin cmd_o.osc   = 1'b1; state_d = StMul1; end
      StMul1:  begin cmd_o.mul1  = 1'b1; state_d = StMul2; end
      StMul2:  begin cmd_o.mul2  = 1'b1; state_d = StMulL; end
      StMulL:  begin cmd_o.mull  = 1'b1; state_d = StMulR; end
      StMulR:  begin cmd_o.mulr  = 1'b1; state_d = StFin;  end
      StFin: begin
        // for a frame's last item, hold until the output register can take the frame
        if (!sts_i.last) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == StIdle);

  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.last && sts_i.out_free)
    else $error("frame emitted without last item or free output");

  a_load_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StPrep)
    else $error("accepted transaction not followed by prep");

  a_wait_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait && sts_i.units_done) |=> state_q == StPhase)
    else $error("units done but phase step skipped");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !sts_i.units_done)
    else $error("arithmetic units not busy after start");

endmodule
